### sv/rsbv_pkg.sv
// Shared types, constants and bit-manipulation functions of the rank/select bit vector.
`timescale 1ns / 1ps

package rsbv_pkg;

  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned WORD_COUNT  = 1024;
  localparam int unsigned WORD_AW     = 10;
  localparam int unsigned SLOT_COUNT  = 129;
  localparam int unsigned SLOT_AW     = 8;
  localparam int unsigned LEN_W       = 17;
  localparam int unsigned REL_W       = 63;
  localparam int unsigned DIR_W       = LEN_W + REL_W;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_SET   = 3'd1,
    CMD_BUILD = 3'd2,
    CMD_RANK  = 3'd3,
    CMD_SEL1  = 3'd4,
    CMD_SEL0  = 3'd5
  } cmd_e;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_UNBUILT = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_SET_RD,
    S_SET_WR,
    S_BLD_RD,
    S_BLD_POP,
    S_BLD_SEL,
    S_BLD_UPD,
    S_BLD_FIN,
    S_RNK_RD,
    S_RNK_SUM,
    S_RNK_ADD,
    S_SEL_SAMP,
    S_SEL_SAMPW,
    S_SEL_LOOP,
    S_SEL_LOOPCK,
    S_SEL_DIR,
    S_SEL_WORD,
    S_SEL_BYTE,
    S_SEL_BIT,
    S_DONE
  } state_e;

  // first half of an in-word select: which byte holds the wanted one
  typedef struct packed {
    logic       hit;
    logic [2:0] byte_idx;
    logic [2:0] rem;
    logic [7:0] byte_val;
  } sel_mid_t;

  function automatic logic [6:0] pop64(input logic [63:0] v);
    logic [6:0] s;
    s = '0;
    for (int i = 0; i < 64; i++) begin
      s = s + 7'(v[i]);
    end
    return s;
  endfunction

  function automatic sel_mid_t sel_stage1(input logic [63:0] w, input logic [16:0] n);
    sel_mid_t   m;
    logic [6:0] pre;
    logic [3:0] pc;
    m   = '0;
    pre = '0;
    for (int b = 0; b < 8; b++) begin
      pc = '0;
      for (int i = 0; i < 8; i++) begin
        pc = pc + 4'(w[8*b+i]);
      end
      if (!m.hit && (n < {10'd0, pre + 7'(pc)})) begin
        m.hit      = 1'b1;
        m.byte_idx = 3'(b);
        m.rem      = n[2:0] - pre[2:0];
        m.byte_val = w[8*b +: 8];
      end
      pre = pre + 7'(pc);
    end
    return m;
  endfunction

  function automatic logic [5:0] sel_stage2(input sel_mid_t m);
    logic [5:0] r;
    logic [3:0] c;
    logic       found;
    r     = 6'd63;
    c     = '0;
    found = 1'b0;
    if (m.hit) begin
      for (int i = 0; i < 8; i++) begin
        if (m.byte_val[i]) begin
          if (!found && (c == {1'b0, m.rem})) begin
            r     = {m.byte_idx, 3'(i)};
            found = 1'b1;
          end
          c = c + 4'd1;
        end
      end
    end
    return r;
  endfunction

  // relative count before word k of a superblock; word 0 has none
  function automatic logic [8:0] rel_field(input logic [62:0] rel, input logic [2:0] k);
    logic [8:0] r;
    r = '0;
    for (int j = 1; j < 8; j++) begin
      if (k == 3'(j)) begin
        r = rel[9*(j-1) +: 9];
      end
    end
    return r;
  endfunction

endpackage

### sv/rsbv_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module rsbv_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/rank_select_bit_vector_core.sv
// Rank/select bit vector: bit store, rank directory, select samples and command sequencer.
// Usage:
//  One command channel (in_valid_i / in_stall_o, fields command, position, bit_value,
//  ordinal) and one result channel (out_valid_o / out_stall_i, fields answer, status).
//  Every command produces exactly one result transaction. Commands are handled one at
//  a time; in_stall_o is high while a command is in progress.
//  Unknown or refused commands go straight to the result; a select that misses its
//  sample walks the directory one superblock at a time; a build takes each stored word
//  through word memory read, popcount, byte select and directory update; a clear
//  writes one word per cycle.
//  After reset the block runs the same clearing pass over the 1024-word store
//  (in_stall_o high) before it accepts the first command.
//  A finished result waits in the output register while out_stall_i is high; the
//  sequencer holds its last state until the register frees up, so nothing is lost.
//  Queries after a set bit or clear need a build first, else they return not-built.
`timescale 1ns / 1ps

module rank_select_bit_vector_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [16:0] position_i,
  input  logic        bit_value_i,
  input  logic [15:0] ordinal_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [16:0] answer_o,
  output logic [1:0]  status_o
);

  rsbv_pkg::state_e state_q, state_d;

  logic [2:0]  cmd_q, cmd_d;
  logic [16:0] pos_q, pos_d;
  logic        val_q, val_d;
  logic [16:0] x_q, x_d;
  logic [16:0] len_q, len_d;
  logic [16:0] ones_tot_q, ones_tot_d;
  logic        built_q, built_d;
  logic [9:0]  clr_idx_q, clr_idx_d;
  logic        clr_res_q, clr_res_d;

  logic [10:0] w_q, w_d;
  logic [10:0] nw_q, nw_d;
  logic [16:0] ones_q, ones_d;
  logic [16:0] abs_q, abs_d;
  logic [62:0] rel_q, rel_d;
  logic [9:0]  n1_q, n1_d, n0_q, n0_d;
  logic [7:0]  c1_q, c1_d, c0_q, c0_d;
  logic [63:0] word_q, word_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [7:0]  s_q, s_d;
  rsbv_pkg::sel_mid_t mid1_q, mid1_d, mid0_q, mid0_d;

  logic [16:0] res_ans_q, res_ans_d;
  logic [1:0]  res_st_q, res_st_d;
  logic        out_valid_q, out_valid_d;
  logic [16:0] out_ans_q, out_ans_d;
  logic [1:0]  out_st_q, out_st_d;

  // memory ports
  logic                  wm_we;
  logic [9:0]            wm_waddr, wm_raddr;
  logic [63:0]           wm_wdata, wm_rdata;
  logic                  dm_we;
  logic [7:0]            dm_waddr, dm_raddr;
  logic [79:0]           dm_wdata, dm_rdata;
  logic                  om_we, zm_we;
  logic [7:0]            om_waddr, zm_waddr, sm_raddr;
  logic [16:0]           om_wdata, zm_wdata, om_rdata, zm_rdata;

  // helpers
  logic        want_one;
  logic [17:0] last_sum, nw_sum;
  logic [7:0]  last_slot;
  logic [11:0] fin_sum;
  logic [7:0]  fin_slot;
  logic [16:0] dir_abs;
  logic [62:0] dir_rel;
  logic [16:0] zeros_cnt;
  logic [2:0]  b_k;
  logic [16:0] b_abs, b_ones_nx;
  logic [62:0] b_rel;
  logic [9:0]  b_n1_sum, b_n0_sum;
  logic [5:0]  b_sel1, b_sel0;
  logic [7:0]  s_next;
  logic [16:0] loop_before, dir_before;
  logic [2:0]  q_k;
  logic [16:0] q_bw;
  logic [63:0] q_word;
  logic [8:0]  rank_rel;
  logic [63:0] rank_mask;
  logic        free_out;

  assign want_one  = (cmd_q == rsbv_pkg::CMD_SEL1);
  assign last_sum  = {1'b0, len_q} + 18'd511;
  assign last_slot = last_sum[16:9];
  assign nw_sum    = {1'b0, len_q} + 18'd63;
  assign fin_sum   = {1'b0, nw_q} + 12'd7;
  assign fin_slot  = fin_sum[10:3];
  assign dir_abs   = dm_rdata[79:63];
  assign dir_rel   = dm_rdata[62:0];
  assign zeros_cnt = (len_q >= ones_tot_q) ? (len_q - ones_tot_q) : 17'd0;

  assign b_k       = w_q[2:0];
  assign b_abs     = (b_k == 3'd0) ? ones_q : abs_q;
  assign b_ones_nx = ones_q + 17'(cnt_q);
  assign b_n1_sum  = n1_q + 10'(cnt_q);
  assign b_n0_sum  = n0_q + (10'd64 - 10'(cnt_q));
  assign b_sel1    = rsbv_pkg::sel_stage2(mid1_q);
  assign b_sel0    = rsbv_pkg::sel_stage2(mid0_q);

  assign s_next      = s_q + 8'd1;
  assign loop_before = want_one ? dir_abs : ({s_next, 9'd0} - dir_abs);
  assign dir_before  = want_one ? dir_abs : ({s_q, 9'd0} - dir_abs);

  assign rank_rel  = rsbv_pkg::rel_field(dir_rel, pos_q[8:6]);
  assign rank_mask = ~({64{1'b1}} << pos_q[5:0]);
  assign q_word    = w_q[10] ? 64'd0 : (want_one ? wm_rdata : ~wm_rdata);
  assign free_out  = !out_valid_q || !out_stall_i;

  // relative counts: word k sets its own field and presets all later ones
  always_comb begin
    b_rel = rel_q;
    for (int j = 1; j < 8; j++) begin
      if ((b_k != 3'd0) && (3'(j) == b_k)) begin
        b_rel[9*(j-1) +: 9] = 9'(ones_q - b_abs);
      end else if (3'(j) > b_k) begin
        b_rel[9*(j-1) +: 9] = 9'(b_ones_nx - b_abs);
      end
    end
  end

  // word within the superblock for a select
  always_comb begin
    logic [8:0]  relf;
    logic [10:0] diff;
    logic [16:0] bw;
    logic        ok;
    q_k  = '0;
    q_bw = '0;
    for (int kk = 1; kk < 8; kk++) begin
      relf = rsbv_pkg::rel_field(rel_q, 3'(kk));
      diff = 11'(kk * 64) - {2'b00, relf};
      if (want_one) begin
        bw = {8'd0, relf};
        ok = 1'b1;
      end else begin
        bw = {7'd0, diff[9:0]};
        ok = !diff[10];
      end
      if (ok && (x_q >= bw)) begin
        q_k  = 3'(kk);
        q_bw = bw;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    val_d       = val_q;
    x_d         = x_q;
    len_d       = len_q;
    ones_tot_d  = ones_tot_q;
    built_d     = built_q;
    clr_idx_d   = clr_idx_q;
    clr_res_d   = clr_res_q;
    w_d         = w_q;
    nw_d        = nw_q;
    ones_d      = ones_q;
    abs_d       = abs_q;
    rel_d       = rel_q;
    n1_d        = n1_q;
    n0_d        = n0_q;
    c1_d        = c1_q;
    c0_d        = c0_q;
    word_d      = word_q;
    cnt_d       = cnt_q;
    s_d         = s_q;
    mid1_d      = mid1_q;
    mid0_d      = mid0_q;
    res_ans_d   = res_ans_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_ans_d   = out_ans_q;
    out_st_d    = out_st_q;

    wm_we    = 1'b0;
    wm_waddr = pos_q[15:6];
    wm_wdata = '0;
    wm_raddr = pos_q[15:6];
    dm_we    = 1'b0;
    dm_waddr = '0;
    dm_wdata = '0;
    dm_raddr = s_q;
    om_we    = 1'b0;
    zm_we    = 1'b0;
    om_waddr = c1_q;
    zm_waddr = c0_q;
    om_wdata = '0;
    zm_wdata = '0;
    sm_raddr = {1'b0, x_q[15:9]};

    unique case (state_q)
      rsbv_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = command_i;
          pos_d     = position_i;
          val_d     = bit_value_i;
          x_d       = {1'b0, ordinal_i};
          res_ans_d = '0;
          res_st_d  = rsbv_pkg::STAT_OK;
          unique case (command_i)
            rsbv_pkg::CMD_CLEAR: begin
              len_d      = '0;
              ones_tot_d = '0;
              built_d    = 1'b0;
              clr_idx_d  = '0;
              clr_res_d  = 1'b1;
              state_d    = rsbv_pkg::S_CLR;
            end
            rsbv_pkg::CMD_SET: begin
              if (position_i[16]) begin
                res_st_d = rsbv_pkg::STAT_RANGE;
                state_d  = rsbv_pkg::S_DONE;
              end else begin
                state_d = rsbv_pkg::S_SET_RD;
              end
            end
            rsbv_pkg::CMD_BUILD: begin
              nw_d    = nw_sum[16:6];
              w_d     = '0;
              ones_d  = '0;
              n1_d    = 10'd512;
              n0_d    = 10'd512;
              c1_d    = '0;
              c0_d    = '0;
              state_d = rsbv_pkg::S_BLD_RD;
            end
            rsbv_pkg::CMD_RANK: begin
              if (!built_q) begin
                res_st_d = rsbv_pkg::STAT_UNBUILT;
                state_d  = rsbv_pkg::S_DONE;
              end else if (position_i > len_q) begin
                res_st_d = rsbv_pkg::STAT_RANGE;
                state_d  = rsbv_pkg::S_DONE;
              end else begin
                state_d = rsbv_pkg::S_RNK_RD;
              end
            end
            rsbv_pkg::CMD_SEL1: begin
              if (!built_q) begin
                res_st_d = rsbv_pkg::STAT_UNBUILT;
                state_d  = rsbv_pkg::S_DONE;
              end else if ({1'b0, ordinal_i} >= ones_tot_q) begin
                res_st_d = rsbv_pkg::STAT_RANGE;
                state_d  = rsbv_pkg::S_DONE;
              end else begin
                state_d = rsbv_pkg::S_SEL_SAMP;
              end
            end
            rsbv_pkg::CMD_SEL0: begin
              if (!built_q) begin
                res_st_d = rsbv_pkg::STAT_UNBUILT;
                state_d  = rsbv_pkg::S_DONE;
              end else if ({1'b0, ordinal_i} >= zeros_cnt) begin
                res_st_d = rsbv_pkg::STAT_RANGE;
                state_d  = rsbv_pkg::S_DONE;
              end else begin
                state_d = rsbv_pkg::S_SEL_SAMP;
              end
            end
            default: begin
              res_st_d = rsbv_pkg::STAT_RANGE;
              state_d  = rsbv_pkg::S_DONE;
            end
          endcase
        end
      end

      rsbv_pkg::S_CLR: begin
        wm_we     = 1'b1;
        wm_waddr  = clr_idx_q;
        wm_wdata  = '0;
        clr_idx_d = clr_idx_q + 10'd1;
        if (clr_idx_q == 10'(rsbv_pkg::WORD_COUNT - 1)) begin
          res_ans_d = '0;
          res_st_d  = rsbv_pkg::STAT_OK;
          state_d   = clr_res_q ? rsbv_pkg::S_DONE : rsbv_pkg::S_IDLE;
        end
      end

      rsbv_pkg::S_SET_RD: begin
        state_d = rsbv_pkg::S_SET_WR;
      end

      rsbv_pkg::S_SET_WR: begin
        wm_we    = 1'b1;
        wm_wdata = val_q ? (wm_rdata | (64'd1 << pos_q[5:0]))
                         : (wm_rdata & ~(64'd1 << pos_q[5:0]));
        if (pos_q >= len_q) begin
          len_d = pos_q + 17'd1;
        end
        built_d = 1'b0;
        state_d = rsbv_pkg::S_DONE;
      end

      rsbv_pkg::S_BLD_RD: begin
        wm_raddr = w_q[9:0];
        if (w_q == nw_q) begin
          state_d = rsbv_pkg::S_BLD_FIN;
        end else begin
          state_d = rsbv_pkg::S_BLD_POP;
        end
      end

      rsbv_pkg::S_BLD_POP: begin
        word_d  = wm_rdata;
        cnt_d   = rsbv_pkg::pop64(wm_rdata);
        state_d = rsbv_pkg::S_BLD_SEL;
      end

      rsbv_pkg::S_BLD_SEL: begin
        mid1_d  = rsbv_pkg::sel_stage1(word_q, {7'd0, 10'd512 - n1_q});
        mid0_d  = rsbv_pkg::sel_stage1(~word_q, {7'd0, 10'd512 - n0_q});
        state_d = rsbv_pkg::S_BLD_UPD;
      end

      rsbv_pkg::S_BLD_UPD: begin
        abs_d = b_abs;
        rel_d = b_rel;
        if ((b_k == 3'd7) || (w_q == nw_q - 11'd1)) begin
          dm_we    = 1'b1;
          dm_waddr = w_q[10:3];
          dm_wdata = {b_abs, b_rel};
        end
        if (b_n1_sum > 10'd512) begin
          om_we    = (c1_q < 8'(rsbv_pkg::SLOT_COUNT));
          om_wdata = {1'b0, w_q[9:0], b_sel1};
          c1_d     = c1_q + 8'd1;
          n1_d     = b_n1_sum - 10'd512;
        end else begin
          n1_d = b_n1_sum;
        end
        if (b_n0_sum > 10'd512) begin
          zm_we    = (c0_q < 8'(rsbv_pkg::SLOT_COUNT));
          zm_wdata = {1'b0, w_q[9:0], b_sel0};
          c0_d     = c0_q + 8'd1;
          n0_d     = b_n0_sum - 10'd512;
        end else begin
          n0_d = b_n0_sum;
        end
        ones_d  = b_ones_nx;
        w_d     = w_q + 11'd1;
        state_d = rsbv_pkg::S_BLD_RD;
      end

      rsbv_pkg::S_BLD_FIN: begin
        dm_we      = 1'b1;
        dm_waddr   = fin_slot;
        dm_wdata   = {ones_q, rel_q};
        om_we      = (c1_q < 8'(rsbv_pkg::SLOT_COUNT));
        om_wdata   = len_q;
        zm_we      = (c0_q < 8'(rsbv_pkg::SLOT_COUNT));
        zm_wdata   = len_q;
        ones_tot_d = ones_q;
        built_d    = 1'b1;
        state_d    = rsbv_pkg::S_DONE;
      end

      rsbv_pkg::S_RNK_RD: begin
        dm_raddr = pos_q[16:9];
        state_d  = rsbv_pkg::S_RNK_SUM;
      end

      rsbv_pkg::S_RNK_SUM: begin
        cnt_d     = rsbv_pkg::pop64(wm_rdata & rank_mask);
        res_ans_d = dir_abs + {8'd0, rank_rel};
        state_d   = rsbv_pkg::S_RNK_ADD;
      end

      rsbv_pkg::S_RNK_ADD: begin
        res_ans_d = res_ans_q + 17'(cnt_q);
        state_d   = rsbv_pkg::S_DONE;
      end

      rsbv_pkg::S_SEL_SAMP: begin
        state_d = rsbv_pkg::S_SEL_SAMPW;
      end

      rsbv_pkg::S_SEL_SAMPW: begin
        if (x_q[8:0] == 9'd0) begin
          res_ans_d = want_one ? om_rdata : zm_rdata;
          state_d   = rsbv_pkg::S_DONE;
        end else begin
          s_d     = want_one ? om_rdata[16:9] : zm_rdata[16:9];
          state_d = rsbv_pkg::S_SEL_LOOP;
        end
      end

      rsbv_pkg::S_SEL_LOOP: begin
        if (s_q < last_slot) begin
          dm_raddr = s_next;
          state_d  = rsbv_pkg::S_SEL_LOOPCK;
        end else begin
          state_d = rsbv_pkg::S_SEL_DIR;
        end
      end

      rsbv_pkg::S_SEL_LOOPCK: begin
        if (x_q >= loop_before) begin
          s_d     = s_next;
          state_d = rsbv_pkg::S_SEL_LOOP;
        end else begin
          state_d = rsbv_pkg::S_SEL_DIR;
        end
      end

      rsbv_pkg::S_SEL_DIR: begin
        x_d     = x_q - dir_before;
        rel_d   = s_q[7] ? 63'd0 : dir_rel;
        state_d = rsbv_pkg::S_SEL_WORD;
      end

      rsbv_pkg::S_SEL_WORD: begin
        x_d      = x_q - q_bw;
        w_d      = {s_q, q_k};
        wm_raddr = {s_q[6:0], q_k};
        state_d  = rsbv_pkg::S_SEL_BYTE;
      end

      rsbv_pkg::S_SEL_BYTE: begin
        mid1_d  = rsbv_pkg::sel_stage1(q_word, x_q);
        state_d = rsbv_pkg::S_SEL_BIT;
      end

      rsbv_pkg::S_SEL_BIT: begin
        res_ans_d = {w_q, b_sel1};
        state_d   = rsbv_pkg::S_DONE;
      end

      rsbv_pkg::S_DONE: begin
        if (free_out) begin
          out_valid_d = 1'b1;
          out_ans_d   = (res_st_q == rsbv_pkg::STAT_OK) ? res_ans_q : 17'd0;
          out_st_d    = res_st_q;
          state_d     = rsbv_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsbv_pkg::S_CLR;
      len_q       <= '0;
      ones_tot_q  <= '0;
      built_q     <= 1'b0;
      clr_idx_q   <= '0;
      clr_res_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      ones_tot_q  <= ones_tot_d;
      built_q     <= built_d;
      clr_idx_q   <= clr_idx_d;
      clr_res_q   <= clr_res_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    x_q       <= x_d;
    w_q       <= w_d;
    nw_q      <= nw_d;
    ones_q    <= ones_d;
    abs_q     <= abs_d;
    rel_q     <= rel_d;
    n1_q      <= n1_d;
    n0_q      <= n0_d;
    c1_q      <= c1_d;
    c0_q      <= c0_d;
    word_q    <= word_d;
    cnt_q     <= cnt_d;
    s_q       <= s_d;
    mid1_q    <= mid1_d;
    mid0_q    <= mid0_d;
    res_ans_q <= res_ans_d;
    res_st_q  <= res_st_d;
    out_ans_q <= out_ans_d;
    out_st_q  <= out_st_d;
  end

  rsbv_ram #(
    .WIDTH(64),
    .DEPTH(1024)
  ) u_word_ram (
    .clk_i  (clk_i),
    .we_i   (wm_we),
    .waddr_i(wm_waddr),
    .wdata_i(wm_wdata),
    .raddr_i(wm_raddr),
    .rdata_o(wm_rdata)
  );

  // absolute count and seven relative counts per superblock
  rsbv_ram #(
    .WIDTH(80),
    .DEPTH(129)
  ) u_dir_ram (
    .clk_i  (clk_i),
    .we_i   (dm_we),
    .waddr_i(dm_waddr),
    .wdata_i(dm_wdata),
    .raddr_i(dm_raddr),
    .rdata_o(dm_rdata)
  );

  rsbv_ram #(
    .WIDTH(17),
    .DEPTH(129)
  ) u_one_ram (
    .clk_i  (clk_i),
    .we_i   (om_we),
    .waddr_i(om_waddr),
    .wdata_i(om_wdata),
    .raddr_i(sm_raddr),
    .rdata_o(om_rdata)
  );

  rsbv_ram #(
    .WIDTH(17),
    .DEPTH(129)
  ) u_zero_ram (
    .clk_i  (clk_i),
    .we_i   (zm_we),
    .waddr_i(zm_waddr),
    .wdata_i(zm_wdata),
    .raddr_i(sm_raddr),
    .rdata_o(zm_rdata)
  );

  assign in_stall_o  = (state_q != rsbv_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign answer_o    = out_ans_q;
  assign status_o    = out_st_q;

endmodule

### dv/tb_top.sv
// Self-checking testbench for the rank/select bit vector core.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] CMD_BAD6 = 3'd6;
  localparam logic [2:0] CMD_BAD7 = 3'd7;
  localparam int unsigned MAX_POS = 65536;
  localparam int unsigned STALL_LIMIT = 40000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [16:0] answer;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [16:0] pos;
    logic        val;
    logic [15:0] ord;
    logic        typed;
    logic [16:0] answer;
    logic [1:0]  status;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  command_i;
  logic [16:0] position_i;
  logic        bit_value_i;
  logic [15:0] ordinal_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [16:0] answer_o;
  logic [1:0]  status_o;

  // shadow copy of the bit store
  logic [63:0] shadow_words [rsbv_pkg::WORD_COUNT];
  int unsigned shadow_len;
  int unsigned shadow_ones;
  bit          shadow_built;

  result_t     pending_results [$];
  int unsigned error_count;
  int unsigned idle_mode;
  int unsigned results_seen;
  int unsigned quiet_cycles = 0;

  rank_select_bit_vector_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .position_i (position_i),
    .bit_value_i(bit_value_i),
    .ordinal_i  (ordinal_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .answer_o   (answer_o),
    .status_o   (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned ones_in(input logic [63:0] w);
    int unsigned c;
    c = 0;
    for (int i = 0; i < 64; i++) c += w[i];
    return c;
  endfunction

  // position of the n-th one (want_one) or zero of the shadow store
  function automatic int unsigned locate_bit(input int unsigned n, input bit want_one);
    int unsigned seen;
    int unsigned cnt;
    logic [63:0] w;
    seen = 0;
    for (int unsigned wi = 0; wi < rsbv_pkg::WORD_COUNT; wi++) begin
      w   = want_one ? shadow_words[wi] : ~shadow_words[wi];
      cnt = ones_in(w);
      if (seen + cnt > n) begin
        for (int b = 0; b < 64; b++) begin
          if (w[b]) begin
            if (seen == n) return wi * 64 + b;
            seen++;
          end
        end
      end
      seen += cnt;
    end
    return 0;
  endfunction

  function automatic result_t bitvec_predict(input logic [2:0] cmd, input logic [16:0] pos,
                                             input logic val, input logic [15:0] ord);
    result_t     r;
    int unsigned cnt;
    int unsigned wi;
    r = '0;
    case (cmd)
      rsbv_pkg::CMD_CLEAR: begin
        foreach (shadow_words[i]) shadow_words[i] = '0;
        shadow_len   = 0;
        shadow_ones  = 0;
        shadow_built = 1'b0;
      end
      rsbv_pkg::CMD_SET: begin
        if (pos >= MAX_POS) begin
          r.status = rsbv_pkg::STAT_RANGE;
        end else begin
          shadow_words[pos / 64][pos % 64] = val;
          if (pos >= shadow_len) shadow_len = pos + 1;
          shadow_built = 1'b0;
        end
      end
      rsbv_pkg::CMD_BUILD: begin
        shadow_ones = 0;
        foreach (shadow_words[i]) shadow_ones += ones_in(shadow_words[i]);
        shadow_built = 1'b1;
      end
      rsbv_pkg::CMD_RANK, rsbv_pkg::CMD_SEL1, rsbv_pkg::CMD_SEL0: begin
        if (!shadow_built) begin
          r.status = rsbv_pkg::STAT_UNBUILT;
        end else if (cmd == rsbv_pkg::CMD_RANK) begin
          if (pos > shadow_len) begin
            r.status = rsbv_pkg::STAT_RANGE;
          end else begin
            cnt = 0;
            wi  = pos / 64;
            for (int unsigned i = 0; i < wi; i++) cnt += ones_in(shadow_words[i]);
            if (wi < rsbv_pkg::WORD_COUNT)
              cnt += ones_in(shadow_words[wi] & ((64'd1 << (pos % 64)) - 64'd1));
            r.answer = 17'(cnt);
          end
        end else if (cmd == rsbv_pkg::CMD_SEL1) begin
          if (ord >= shadow_ones) r.status = rsbv_pkg::STAT_RANGE;
          else r.answer = 17'(locate_bit(ord, 1'b1));
        end else begin
          if (ord >= shadow_len - shadow_ones) r.status = rsbv_pkg::STAT_RANGE;
          else r.answer = 17'(locate_bit(ord, 1'b0));
        end
      end
      default: r.status = rsbv_pkg::STAT_RANGE;
    endcase
    return r;
  endfunction

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  task automatic send_command(input logic [2:0] cmd, input logic [16:0] pos, input logic val,
                              input logic [15:0] ord, input bit typed = 1'b0,
                              input result_t typed_res = '0);
    result_t r;
    int unsigned gap_pct;
    gap_pct = (idle_mode == 0) ? 23 : (idle_mode == 1) ? 49 : 0;
    while (roll(gap_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    position_i  <= pos;
    bit_value_i <= val;
    ordinal_i   <= ord;
    do @(posedge clk_i); while (in_stall_o);
    r = bitvec_predict(cmd, pos, val, ord);
    if (typed) r = typed_res;
    pending_results = {pending_results, r};
  endtask

  // receiver: check results
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: answer %0d status %0d", answer_o, status_o);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (answer_o !== exp_r.answer) begin
          $error("answer mismatch: expected %0d actual %0d", exp_r.answer, answer_o);
          error_count++;
        end
        if (status_o !== exp_r.status) begin
          $error("status mismatch: expected %0d actual %0d", exp_r.status, status_o);
          error_count++;
        end
      end
    end
  end

  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  always @(posedge clk_i) begin
    int unsigned stall_pct;
    stall_pct = (idle_mode == 0) ? 49 : (idle_mode == 1) ? 23 : 0;
    // one long hold-off so the block backs up onto its input
    if (!hold_done && results_seen == 300) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= roll(stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  stim_row_t directed_rows [27];

  initial begin
    int unsigned items;
    int unsigned span;
    int unsigned n;
    logic [16:0] p;
    logic [15:0] o;
    logic [2:0]  qc;

    directed_rows = '{
      '{rsbv_pkg::CMD_RANK,  17'd0,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_UNBUILT},
      '{rsbv_pkg::CMD_SEL1,  17'd0,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_UNBUILT},
      '{rsbv_pkg::CMD_SEL0,  17'd0,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_UNBUILT},
      '{CMD_BAD6,            17'd0,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_RANGE},
      '{CMD_BAD7,            17'h1ffff, 1'b1, 16'hffff, 1'b1, 17'd0, rsbv_pkg::STAT_RANGE},
      '{rsbv_pkg::CMD_SET,   17'd65536, 1'b1, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_RANGE},
      '{rsbv_pkg::CMD_SET,   17'd0,     1'b1, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_SET,   17'd65535, 1'b1, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_SET,   17'd100,   1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_SEL1,  17'd0,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_UNBUILT},
      '{rsbv_pkg::CMD_BUILD, 17'd0,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_RANK,  17'd65536, 1'b0, 16'd0,    1'b1, 17'd2, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_RANK,  17'd0,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_RANK,  17'd1,     1'b0, 16'd0,    1'b1, 17'd1, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_RANK,  17'd65535, 1'b0, 16'd0,    1'b1, 17'd1, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_SEL1,  17'd0,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_SEL1,  17'd0,     1'b0, 16'd1,    1'b1, 17'd65535,
        rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_SEL1,  17'd0,     1'b0, 16'd2,    1'b1, 17'd0, rsbv_pkg::STAT_RANGE},
      '{rsbv_pkg::CMD_SEL0,  17'd0,     1'b0, 16'd0,    1'b1, 17'd1, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_SEL0,  17'd0,     1'b0, 16'd65533, 1'b1, 17'd65534,
        rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_SEL0,  17'd0,     1'b0, 16'd65534, 1'b1, 17'd0,
        rsbv_pkg::STAT_RANGE},
      '{rsbv_pkg::CMD_SEL1,  17'd0,     1'b0, 16'hffff, 1'b1, 17'd0, rsbv_pkg::STAT_RANGE},
      '{rsbv_pkg::CMD_CLEAR, 17'd0,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_BUILD, 17'd0,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_RANK,  17'd0,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_OK},
      '{rsbv_pkg::CMD_RANK,  17'd1,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_RANGE},
      '{rsbv_pkg::CMD_SEL0,  17'd0,     1'b0, 16'd0,    1'b1, 17'd0, rsbv_pkg::STAT_RANGE}
    };

    foreach (shadow_words[i]) shadow_words[i] = '0;
    shadow_len   = 0;
    shadow_ones  = 0;
    shadow_built = 1'b0;
    error_count  = 0;
    results_seen = 0;
    idle_mode    = 0;
    in_valid_i   = 1'b0;
    command_i    = rsbv_pkg::CMD_CLEAR;
    position_i   = '0;
    bit_value_i  = 1'b0;
    ordinal_i    = '0;
    rst_ni       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].val,
                   directed_rows[i].ord, directed_rows[i].typed,
                   '{directed_rows[i].answer, directed_rows[i].status});

    // random sessions: an occasional clear, a burst of sets, usually a build, then queries
    items = 0;
    while (items < 1200) begin
      idle_mode = (items < 400) ? 0 : (items < 800) ? 1 : 2;
      if (roll(8) || shadow_len > 8192) begin
        send_command(rsbv_pkg::CMD_CLEAR, 17'($urandom), 1'($urandom), 16'($urandom));
        items++;
      end
      span = roll(5) ? MAX_POS : roll(30) ? 2048 : roll(50) ? 600 : 64;
      n = $urandom_range(30, 1);
      repeat (n) begin
        p = roll(3) ? 17'($urandom) : 17'($urandom_range(span - 1, 0));
        send_command(rsbv_pkg::CMD_SET, p, 1'($urandom), 16'($urandom));
        items++;
      end
      if (roll(90)) begin
        send_command(rsbv_pkg::CMD_BUILD, 17'($urandom), 1'($urandom), 16'($urandom));
        items++;
      end
      n = $urandom_range(15, 3);
      repeat (n) begin
        qc = roll(4) ? (roll(50) ? CMD_BAD6 : CMD_BAD7)
                     : 3'($urandom_range(rsbv_pkg::CMD_SEL0, rsbv_pkg::CMD_RANK));
        p = roll(10) ? 17'($urandom) : 17'($urandom_range(shadow_len + 2, 0));
        if (roll(10)) o = 16'($urandom);
        else if (qc == rsbv_pkg::CMD_SEL0)
          o = 16'($urandom_range(shadow_len - shadow_ones + 1, 0));
        else o = 16'($urandom_range(shadow_ones + 1, 0));
        send_command(qc, p, 1'($urandom), o);
        items++;
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
